### sv/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants and controller/datapath interface types for the
// per-row int8 absmax quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam int          MAX_COLUMNS_DEF = 64;
    localparam int          LEN_W           = 7;
    localparam logic [6:0]  ROW_LEN_RESET   = 7'd64;

    // fp32 constants
    localparam logic [31:0] FP_127 = 32'h42FE_0000;
    localparam logic [31:0] FP_INF = 32'h7F80_0000;

    typedef struct packed {
        logic accept_ok;
        logic div_start_scale;
        logic scale_capture;
        logic rd_en;
        logic div_start_elem;
        logic out_load;
        logic idx_inc;
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic div_done;
        logic skip;
        logic last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### sv/prq_ram.sv
// ----------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/prq_fdiv.sv
// ----------------------------------------------------------------------------
// prq_fdiv
// Iterative fp32 magnitude divider, round to nearest even, with subnormal
// operands and results. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_fdiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] a_mag,
    input  wire logic [30:0] b_mag,
    output logic             done,
    output logic      [30:0] result
);

    localparam logic [2:0] FD_IDLE   = 3'd0;
    localparam logic [2:0] FD_NORM   = 3'd1;
    localparam logic [2:0] FD_DIV    = 3'd2;
    localparam logic [2:0] FD_ALIGN  = 3'd3;
    localparam logic [2:0] FD_DENORM = 3'd4;
    localparam logic [2:0] FD_ROUND  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic [23:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic signed [10:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [24:0]        rem_reg, rem_next;
    logic [26:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [10:0] exp_reg, exp_next;
    logic               sticky_reg, sticky_next;
    logic [30:0]        res_reg, res_next;

    logic        ge;
    logic [24:0] rem_sub;
    logic        guard, rnd_sticky, inc;
    logic [7:0]  field;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        sticky_next = sticky_reg;
        res_next    = res_reg;

        ge         = (rem_reg >= {1'b0, mb_reg});
        rem_sub    = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
        guard      = quo_reg[2];
        rnd_sticky = sticky_reg | quo_reg[1] | quo_reg[0];
        inc        = guard & (rnd_sticky | quo_reg[3]);
        field      = quo_reg[26] ? exp_reg[7:0] : 8'd0;

        unique case (state_reg)
            FD_IDLE:
            begin
                if (start)
                begin
                    ma_next = {(a_mag[30:23] != 8'd0), a_mag[22:0]};
                    mb_next = {(b_mag[30:23] != 8'd0), b_mag[22:0]};
                    ea_next = (a_mag[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, a_mag[30:23]});
                    eb_next = (b_mag[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, b_mag[30:23]});
                    if (a_mag == 31'd0)
                    begin
                        res_next  = 31'd0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = FD_NORM;
                    end
                end
            end
            FD_NORM:
            begin
                if (ma_reg[23] && mb_reg[23])
                begin
                    rem_next   = {1'b0, ma_reg};
                    quo_next   = 27'd0;
                    cnt_next   = 5'd0;
                    state_next = FD_DIV;
                end
                else
                begin
                    // shift subnormal significands up one bit a cycle
                    if (!ma_reg[23])
                    begin
                        ma_next = {ma_reg[22:0], 1'b0};
                        ea_next = ea_reg - 11'sd1;
                    end
                    if (!mb_reg[23])
                    begin
                        mb_next = {mb_reg[22:0], 1'b0};
                        eb_next = eb_reg - 11'sd1;
                    end
                end
            end
            FD_DIV:
            begin
                quo_next = {quo_reg[25:0], ge};
                rem_next = {rem_sub[23:0], 1'b0};
                if (cnt_reg == 5'd26)
                begin
                    state_next = FD_ALIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            FD_ALIGN:
            begin
                sticky_next = (rem_reg != 25'd0);
                if (quo_reg[26])
                begin
                    exp_next = ea_reg - eb_reg + 11'sd127;
                end
                else
                begin
                    quo_next = {quo_reg[25:0], 1'b0};
                    exp_next = ea_reg - eb_reg + 11'sd126;
                end
                state_next = FD_DENORM;
            end
            FD_DENORM:
            begin
                // subnormal result: shift right until the exponent reaches the floor
                if ((exp_reg < 11'sd1) && (quo_reg != 27'd0))
                begin
                    quo_next    = {1'b0, quo_reg[26:1]};
                    sticky_next = sticky_reg | quo_reg[0];
                    exp_next    = exp_reg + 11'sd1;
                end
                else
                begin
                    state_next = FD_ROUND;
                end
            end
            FD_ROUND:
            begin
                if (exp_reg >= 11'sd255)
                begin
                    res_next = prq_pkg::FP_INF[30:0];
                end
                else
                begin
                    // carry out of the fraction bumps the exponent field
                    res_next = {field, quo_reg[25:3]} + {30'd0, inc};
                end
                done_next  = 1'b1;
                state_next = FD_IDLE;
            end
            default:
            begin
                state_next = FD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        exp_reg    <= exp_next;
        sticky_reg <= sticky_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### sv/prq_dp.sv
// ----------------------------------------------------------------------------
// prq_dp
// Datapath: row buffer, running absmax, scale and bad flags, shared divider,
// integer rounding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_dp #(
    parameter int MAX_COLUMNS = prq_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire prq_pkg::cmd_t       cmd,
    output prq_pkg::stat_t           st,
    input  wire logic                cfg_wr_en,
    input  wire logic [6:0]          cfg_wr_data,
    input  wire logic                in_valid,
    input  wire logic [31:0]         weight_bits,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [7:0]        quantized_value,
    output logic [31:0]              row_scale_bits,
    output logic                     last_in_row,
    output logic                     bad_row
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LW = prq_pkg::LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_COLUMNS);

    logic [6:0]    row_len_reg;
    logic [LW-1:0] fill_reg;
    logic [30:0]   max_reg;
    logic          nan_reg;
    logic [30:0]   row_max_reg;
    logic          row_nan_reg;
    logic [LW-1:0] row_n_reg;
    logic [31:0]   scale_reg;
    logic          skip_reg;
    logic          bad_reg;
    logic [AW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [7:0]    out_q_reg;
    logic [31:0]   out_scale_reg;
    logic          out_last_reg;
    logic          out_bad_reg;

    logic          in_fire;
    logic [30:0]   mag;
    logic          is_nan;
    logic [30:0]   max_upd;
    logic          nan_upd;
    logic [6:0]    eff_len;
    logic [LW-1:0] fill_base;
    logic [LW-1:0] fill_inc;
    logic          complete;
    logic [31:0]   rd_data;

    logic          div_start;
    logic [30:0]   div_a;
    logic [30:0]   div_b;
    logic          div_done;
    logic [30:0]   div_res;

    logic          max_inf;
    logic [31:0]   scale_val;
    logic          scale_zero;

    logic [7:0]    q_exp;
    logic [2:0]    q_sh;
    logic [31:0]   q_scaled;
    logic [8:0]    q_t;
    logic [6:0]    q_mag;
    logic [7:0]    q_val;

    assign in_fire = in_valid & cmd.accept_ok;
    assign mag     = weight_bits[30:0];
    assign is_nan  = (mag[30:23] == 8'hFF) && (mag[22:0] != 23'd0);
    // magnitudes of non-nan values order like unsigned integers
    assign max_upd = (!is_nan && (mag > max_reg)) ? mag : max_reg;
    assign nan_upd = nan_reg | is_nan;

    assign eff_len = (row_len_reg == 7'd0) ? 7'd1 :
                     (row_len_reg > 7'(MAX_LEN)) ? 7'(MAX_LEN) : row_len_reg;
    assign fill_base = (fill_reg >= MAX_LEN) ? '0 : fill_reg;
    assign fill_inc  = fill_base + LW'(1);
    assign complete  = (7'(fill_inc) >= eff_len);

    prq_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (fill_base[AW-1:0]),
        .wdata (weight_bits),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign div_start = cmd.div_start_scale | cmd.div_start_elem;
    assign div_a     = cmd.div_start_scale ? row_max_reg : rd_data[30:0];
    assign div_b     = cmd.div_start_scale ? prq_pkg::FP_127[30:0] : scale_reg[30:0];

    prq_fdiv u_fdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a_mag  (div_a),
        .b_mag  (div_b),
        .done   (div_done),
        .result (div_res)
    );

    assign max_inf    = (row_max_reg[30:23] == 8'hFF);
    assign scale_val  = max_inf ? prq_pkg::FP_INF : {1'b0, div_res};
    assign scale_zero = (scale_val == 32'd0);

    // round the fp32 quotient half away from zero, clamp to 127
    always_comb
    begin
        q_exp    = div_res[30:23];
        q_sh     = 3'(q_exp - 8'd126);
        q_scaled = {8'd0, 1'b1, div_res[22:0]} << q_sh;
        q_t      = {1'b0, q_scaled[31:24]} + {8'd0, q_scaled[23]};
        if (q_exp < 8'd126)
        begin
            q_mag = 7'd0;
        end
        else if ((q_exp > 8'd133) || (q_t > 9'd127))
        begin
            q_mag = 7'd127;
        end
        else
        begin
            q_mag = q_t[6:0];
        end
        if (skip_reg)
        begin
            q_val = 8'd0;
        end
        else if (rd_data[31])
        begin
            q_val = 8'd0 - {1'b0, q_mag};
        end
        else
        begin
            q_val = {1'b0, q_mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg   <= prq_pkg::ROW_LEN_RESET;
            fill_reg      <= '0;
            max_reg       <= 31'd0;
            nan_reg       <= 1'b0;
            idx_reg       <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                row_len_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                if (complete)
                begin
                    fill_reg <= '0;
                    max_reg  <= 31'd0;
                    nan_reg  <= 1'b0;
                end
                else
                begin
                    fill_reg <= fill_inc;
                    max_reg  <= max_upd;
                    nan_reg  <= nan_upd;
                end
            end
            if (cmd.scale_capture)
            begin
                idx_reg  <= '0;
                skip_reg <= scale_zero | max_inf | row_nan_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && complete)
        begin
            row_max_reg <= max_upd;
            row_nan_reg <= nan_upd;
            row_n_reg   <= fill_inc;
        end
        if (cmd.scale_capture)
        begin
            scale_reg <= scale_val;
            bad_reg   <= max_inf | (row_nan_reg & !scale_zero);
        end
        if (cmd.out_load)
        begin
            out_q_reg     <= q_val;
            out_scale_reg <= scale_reg;
            out_last_reg  <= st.last;
            out_bad_reg   <= bad_reg;
        end
    end

    assign st.row_done = in_fire & complete;
    assign st.div_done = div_done;
    assign st.skip     = skip_reg;
    assign st.last     = ((LW'(idx_reg) + LW'(1)) == row_n_reg);
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign quantized_value = out_q_reg;
    assign row_scale_bits  = out_scale_reg;
    assign last_in_row     = out_last_reg;
    assign bad_row         = out_bad_reg;

endmodule

`default_nettype wire

### sv/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Controller: load phase, scale divide, then per-element read, divide (skipped for zero or bad rows), emit.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire prq_pkg::stat_t  st,
    output prq_pkg::cmd_t        cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SCALE      = 3'd1;
    localparam logic [2:0] S_SCALE_WAIT = 3'd2;
    localparam logic [2:0] S_READ       = 3'd3;
    localparam logic [2:0] S_ELEM       = 3'd4;
    localparam logic [2:0] S_ELEM_WAIT  = 3'd5;
    localparam logic [2:0] S_EMIT       = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept_ok = 1'b1;
                if (st.row_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.div_start_scale = 1'b1;
                state_next          = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.scale_capture = 1'b1;
                    state_next        = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ELEM;
            end
            S_ELEM:
            begin
                // zero or bad rows emit zeros without dividing
                if (st.skip)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_start_elem = 1'b1;
                    state_next         = S_ELEM_WAIT;
                end
            end
            S_ELEM_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (st.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/per_row_int8_absmax_quantizer.sv
// ----------------------------------------------------------------------------
// per_row_int8_absmax_quantizer
// Symmetric per-row int8 quantizer: buffers a row of fp32 weights, takes
// scale = absmax/127 and emits each weight divided by the scale, rounded
// half away from zero and clamped to +-127.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_wr_en            cfg_wr_data (row_length)
//   in       in   in_valid / in_stall  weight_bits
//   out      out  out_valid/out_stall  quantized_value, row_scale_bits,
//                                      last_in_row, bad_row
//
// a weight that does not complete a row is taken without a stall
// the completing beat starts the scale divide
// each result then comes from the shared divider, which retires one quotient
// bit per cycle; zero or bad rows skip the divide; subnormals add shift steps
// async reset, no clearing pass; input stalls from row completion until the
// last beat of the row is loaded into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module per_row_int8_absmax_quantizer #(
    parameter int MAX_COLUMNS = prq_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [6:0]   cfg_wr_data,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [31:0]  weight_bits,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic signed [7:0] quantized_value,
    output logic [31:0]       row_scale_bits,
    output logic              last_in_row,
    output logic              bad_row
);

    prq_pkg::cmd_t  cmd;
    prq_pkg::stat_t st;

    prq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    prq_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .weight_bits     (weight_bits),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quantized_value (quantized_value),
        .row_scale_bits  (row_scale_bits),
        .last_in_row     (last_in_row),
        .bad_row         (bad_row)
    );

    assign in_stall = !cmd.accept_ok;

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register loaded while occupied");

    a_no_div_skip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start_elem |-> !st.skip)
        else $error("element divide started on a skipped row");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_row) |-> (quantized_value == 8'sd0))
        else $error("bad row carries a nonzero value");

    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (row_scale_bits == 32'd0)) |-> (quantized_value == 8'sd0))
        else $error("zero scale row carries a nonzero value");

    a_row_stall: assert property (@(posedge clk) disable iff (!rst_n)
        st.row_done |=> in_stall)
        else $error("input not stalled after row completion");
`endif

endmodule

`default_nettype wire
